>>> rtl/tscr_pkg.sv
// Shared command codes and sequencer state type for the tile scroll column ring.
// No dependencies.
`default_nettype none
package tscr_pkg;

	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_INIT   = 2'd1;
	localparam logic [1:0] CMD_SCROLL = 2'd2;
	localparam logic [1:0] CMD_READ   = 2'd3;

	localparam int CODE_W  = 6;
	localparam int FRAME_W = 2;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} walk_state_t;

endpackage
`default_nettype wire

>>> rtl/tscr_sram.sv
// Single-port-write, single-port-read synchronous memory with a registered read port.
// No dependencies.
`default_nettype none
module tscr_sram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 768
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/tscr_walker.sv
// Column refill sequencer: holds ring start, camera column and frame, and streams
// map columns into the ring one row per cycle. Depends on tscr_pkg.
`default_nettype none
module tscr_walker #(
	parameter int VIEW_COLS = 32,
	parameter int VIEW_ROWS = 24,
	parameter int MAP_COLS  = 256,
	parameter int MAP_ROWS  = 24
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     go_init,
	input  wire logic                                     go_scroll,
	input  wire logic [15:0]                              cam_x,
	output logic                                          busy,
	output logic      [$clog2(VIEW_COLS)-1:0]             ring_start,
	output logic      [tscr_pkg::FRAME_W-1:0]             frame_sel,
	output logic                                          map_re,
	output logic      [$clog2(MAP_ROWS*MAP_COLS)-1:0]     map_raddr,
	input  wire logic [tscr_pkg::CODE_W-1:0]              map_rdata,
	output logic                                          ring_we,
	output logic      [$clog2(VIEW_ROWS*VIEW_COLS)-1:0]   ring_waddr,
	output logic      [tscr_pkg::CODE_W-1:0]              ring_wdata
);

	localparam int RCW       = $clog2(VIEW_COLS);
	localparam int MCW       = $clog2(MAP_COLS);
	localparam int RW        = (VIEW_ROWS > 1) ? $clog2(VIEW_ROWS) : 1;
	localparam int ICW       = $clog2(VIEW_COLS + 1);
	localparam int MAW       = $clog2(MAP_ROWS * MAP_COLS);
	localparam int RAW       = $clog2(VIEW_ROWS * VIEW_COLS);
	localparam int CAM_LIMIT = (MAP_COLS - VIEW_COLS) * 8;

	tscr_pkg::walk_state_t state_q, state_d;

	logic [RW-1:0]                  row_q;
	logic [ICW-1:0]                 icol_q;
	logic [MCW-1:0]                 sx_q;
	logic [MCW-1:0]                 tgt_q;
	logic [RCW-1:0]                 idx_q;
	logic [tscr_pkg::FRAME_W-1:0]   frame_q;
	logic                           init_q;

	logic                           we_s1;
	logic                           zero_s1;
	logic [RAW-1:0]                 waddr_s1;

	logic                           fwd;
	logic                           bwd;
	logic                           more;
	logic                           col_ok;
	logic                           row_in_map;
	logic                           last_row;
	logic                           issue;
	logic [MCW-1:0]                 mcol;
	logic [RCW-1:0]                 rcol;
	logic [RCW-1:0]                 idx_prev;
	logic [RCW-1:0]                 idx_next;
	logic [15:0]                    cam_clamped;

	always_comb begin
		fwd        = sx_q < tgt_q;
		bwd        = sx_q > tgt_q;
		idx_prev   = (idx_q == '0) ? RCW'(VIEW_COLS - 1) : idx_q - 1'b1;
		idx_next   = (32'(idx_q) == VIEW_COLS - 1) ? '0 : idx_q + 1'b1;
		row_in_map = 32'(row_q) < MAP_ROWS;
		last_row   = 32'(row_q) == VIEW_ROWS - 1;
		if (init_q) begin
			more   = 32'(icol_q) < VIEW_COLS;
			col_ok = 32'(icol_q) < MAP_COLS;
			mcol   = MCW'(32'(icol_q));
			rcol   = RCW'(icol_q);
		end else begin
			more   = fwd || bwd;
			col_ok = 1'b1;
			mcol   = fwd ? MCW'(32'(sx_q) + VIEW_COLS) : sx_q - 1'b1;
			rcol   = fwd ? idx_q : idx_prev;
		end
		cam_clamped = (32'(cam_x) > CAM_LIMIT) ? 16'(CAM_LIMIT) : cam_x;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tscr_pkg::ST_IDLE: begin
				if (go_init || go_scroll) begin
					state_d = tscr_pkg::ST_WALK;
				end
			end
			tscr_pkg::ST_WALK: begin
				if (!more) begin
					state_d = tscr_pkg::ST_IDLE;
				end
			end
			default: state_d = tscr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy  = 1'b0;
		issue = 1'b0;
		unique case (state_q)
			tscr_pkg::ST_IDLE: begin
				busy = 1'b0;
			end
			tscr_pkg::ST_WALK: begin
				busy  = 1'b1;
				issue = more;
			end
			default: busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tscr_pkg::ST_IDLE;
			row_q   <= '0;
			icol_q  <= '0;
			sx_q    <= '0;
			tgt_q   <= '0;
			idx_q   <= '0;
			frame_q <= '0;
			init_q  <= 1'b0;
			we_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			we_s1   <= issue && col_ok;
			if (state_q == tscr_pkg::ST_IDLE && go_init) begin
				init_q  <= 1'b1;
				icol_q  <= '0;
				sx_q    <= '0;
				tgt_q   <= '0;
				idx_q   <= '0;
				frame_q <= '0;
				row_q   <= '0;
			end else if (state_q == tscr_pkg::ST_IDLE && go_scroll) begin
				init_q  <= 1'b0;
				frame_q <= cam_clamped[2:1];
				tgt_q   <= MCW'(cam_clamped >> 3);
				row_q   <= '0;
			end else if (issue && last_row) begin
				row_q <= '0;
				if (init_q) begin
					icol_q <= icol_q + 1'b1;
				end else if (fwd) begin
					sx_q  <= sx_q + 1'b1;
					idx_q <= idx_next;
				end else begin
					sx_q  <= sx_q - 1'b1;
					idx_q <= idx_prev;
				end
			end else if (issue) begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		zero_s1  <= !row_in_map;
		waddr_s1 <= RAW'(32'(row_q) * VIEW_COLS + 32'(rcol));
	end

	assign map_re     = issue && col_ok && row_in_map;
	assign map_raddr  = MAW'(32'(row_q) * MAP_COLS + 32'(mcol));
	assign ring_we    = we_s1;
	assign ring_waddr = waddr_s1;
	assign ring_wdata = zero_s1 ? '0 : map_rdata;
	assign ring_start = idx_q;
	assign frame_sel  = frame_q;

endmodule
`default_nettype wire

>>> rtl/tile_scroll_column_ring_top.sv
// Top level of the tile scroll column ring: command decode, map and ring memories,
// name read path. Depends on tscr_pkg, tscr_sram and tscr_walker.
//
// Write and read commands are accepted while busy is low and may follow back to back;
// a read's tile_name and frame_now appear, marked by done, in the cycle after the
// transfer and must be taken then. Init holds busy while it refills every ring column,
// and a scroll while it refills one column per map column crossed: the refill copies
// one map entry per cycle through the single map read port into the ring.
`default_nettype none
module tile_scroll_column_ring_top #(
	parameter int VIEW_COLS = 32,
	parameter int VIEW_ROWS = 24,
	parameter int MAP_COLS  = 256,
	parameter int MAP_ROWS  = 24
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] cmd,
	input  wire logic [15:0] cam_x,
	input  wire logic [7:0] map_col,
	input  wire logic [4:0] map_row,
	input  wire logic [5:0] pair_code,
	input  wire logic [4:0] view_col,
	input  wire logic [4:0] view_row,
	output logic            done,
	output logic      [7:0] tile_name,
	output logic      [1:0] frame_now
);

	localparam int RCW = $clog2(VIEW_COLS);
	localparam int MAW = $clog2(MAP_ROWS * MAP_COLS);
	localparam int RAW = $clog2(VIEW_ROWS * VIEW_COLS);

	logic                          accept;
	logic                          map_we;
	logic [MAW-1:0]                map_waddr;
	logic                          map_re;
	logic [MAW-1:0]                map_raddr;
	logic [tscr_pkg::CODE_W-1:0]   map_rdata;
	logic                          ring_we;
	logic [RAW-1:0]                ring_waddr;
	logic [tscr_pkg::CODE_W-1:0]   ring_wdata;
	logic                          ring_re;
	logic [RAW-1:0]                ring_raddr;
	logic [tscr_pkg::CODE_W-1:0]   ring_rdata;
	logic [RCW-1:0]                ring_start;
	logic [tscr_pkg::FRAME_W-1:0]  frame_sel;
	logic                          view_ok;
	logic [31:0]                   rc_sum;
	logic [RCW-1:0]                rc;
	logic                          done_q;
	logic                          ok_s1;
	logic [tscr_pkg::FRAME_W-1:0]  frame_s1;

	assign accept = start && !busy;

	always_comb begin
		map_we    = accept && cmd == tscr_pkg::CMD_WRITE &&
			32'(map_col) < MAP_COLS && 32'(map_row) < MAP_ROWS;
		map_waddr = MAW'(32'(map_row) * MAP_COLS + 32'(map_col));
		view_ok   = 32'(view_col) < VIEW_COLS && 32'(view_row) < VIEW_ROWS;
		rc_sum    = 32'(ring_start) + 32'(view_col);
		rc        = (rc_sum >= VIEW_COLS) ? RCW'(rc_sum - VIEW_COLS) : RCW'(rc_sum);
		ring_re   = accept && cmd == tscr_pkg::CMD_READ && view_ok;
		ring_raddr = RAW'(32'(view_row) * VIEW_COLS + 32'(rc));
	end

	tscr_sram #(
		.WIDTH(tscr_pkg::CODE_W),
		.DEPTH(MAP_ROWS * MAP_COLS)
	) u_map (
		.clk  (clk),
		.we   (map_we),
		.waddr(map_waddr),
		.wdata(pair_code),
		.re   (map_re),
		.raddr(map_raddr),
		.rdata(map_rdata)
	);

	tscr_sram #(
		.WIDTH(tscr_pkg::CODE_W),
		.DEPTH(VIEW_ROWS * VIEW_COLS)
	) u_ring (
		.clk  (clk),
		.we   (ring_we),
		.waddr(ring_waddr),
		.wdata(ring_wdata),
		.re   (ring_re),
		.raddr(ring_raddr),
		.rdata(ring_rdata)
	);

	tscr_walker #(
		.VIEW_COLS(VIEW_COLS),
		.VIEW_ROWS(VIEW_ROWS),
		.MAP_COLS (MAP_COLS),
		.MAP_ROWS (MAP_ROWS)
	) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.go_init   (accept && cmd == tscr_pkg::CMD_INIT),
		.go_scroll (accept && cmd == tscr_pkg::CMD_SCROLL),
		.cam_x     (cam_x),
		.busy      (busy),
		.ring_start(ring_start),
		.frame_sel (frame_sel),
		.map_re    (map_re),
		.map_raddr (map_raddr),
		.map_rdata (map_rdata),
		.ring_we   (ring_we),
		.ring_waddr(ring_waddr),
		.ring_wdata(ring_wdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept && cmd == tscr_pkg::CMD_READ;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1    <= view_ok;
		frame_s1 <= frame_sel;
	end

	assign done      = done_q;
	assign frame_now = frame_s1;
	assign tile_name = ok_s1 ? {ring_rdata, frame_s1} : '0;

	a_done_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && cmd == tscr_pkg::CMD_READ))
		else $error("result strobe without a read transfer");

	a_refill_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ring_we |-> busy)
		else $error("ring write outside a refill");

	a_map_ports_apart: assert property (@(posedge clk) disable iff (!arst_n)
		!(map_we && map_re))
		else $error("map write during refill read");

	a_ring_ports_apart: assert property (@(posedge clk) disable iff (!arst_n)
		!(ring_we && ring_re))
		else $error("ring read during refill write");

endmodule
`default_nettype wire
